// ===== hw/rtl/orb_pkg.sv =====
// Shared constants, codes and result types for the overwriting sample ring buffer.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package orb_pkg;

  // Buffer geometry.
  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = ADDR_W + 1;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned REQ_W     = 7;
  localparam int unsigned QCNT_W    = 2;

  // Operation codes carried in func.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_PEEK  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // One result as delivered on the output channel.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       last_of_run;
    logic [REQ_W-1:0]           delivered_count;
    logic [CNT_W-1:0]           fill_level;
    logic                       status;
  } result_t;

  // Result in flight while the memory read completes.
  typedef struct packed {
    logic    valid;
    logic    use_ram;
    result_t res;
  } stage_t;

  // Advance a buffer index by one with wraparound.
  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    if (p == ADDR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ADDR_W'(1);
    end
    return r;
  endfunction

  // Fold a sum below twice the depth back into the index range.
  function automatic logic [ADDR_W-1:0] wrap_fold(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    if (s >= SUM_W'(DEPTH)) begin
      r = s - SUM_W'(DEPTH);
    end else begin
      r = s;
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/orb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; used for the sample store.
`default_nettype none

module orb_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; read data is registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/orb_outq.sv =====
// Two-entry result queue that decouples the output channel from the sequencer.
// Depends on orb_pkg for the result type.
`default_nettype none

module orb_outq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire orb_pkg::result_t            push_data,
  input  wire logic                        pop,
  output orb_pkg::result_t                 head_data,
  output logic [orb_pkg::QCNT_W-1:0]       count
);

  orb_pkg::result_t entries [2];
  logic             head;
  logic             tail;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + orb_pkg::QCNT_W'(push) - orb_pkg::QCNT_W'(pop);
    end
  end

  assign head_data = entries[head];

endmodule

`default_nettype wire

// ===== hw/rtl/orb_ctrl.sv =====
// Sequencer for the ring buffer: pointers, fill count, burst reads and result staging.
// Depends on orb_pkg; drives the ports of the sample RAM.
`default_nettype none

module orb_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     func,
  input  wire logic [orb_pkg::SAMPLE_W-1:0]   sample_in,
  input  wire logic [orb_pkg::REQ_W-1:0]      request_count,
  input  wire logic [orb_pkg::QCNT_W-1:0]     q_count,
  input  wire logic                           q_pop,
  output logic                                ram_we,
  output logic [orb_pkg::ADDR_W-1:0]          ram_waddr,
  output logic [orb_pkg::SAMPLE_W-1:0]        ram_wdata,
  output logic                                ram_re,
  output logic [orb_pkg::ADDR_W-1:0]          ram_raddr,
  output orb_pkg::stage_t                     stage
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  logic                         state;
  logic                         state_next;
  logic [orb_pkg::ADDR_W-1:0]   write_pointer;
  logic [orb_pkg::ADDR_W-1:0]   write_pointer_next;
  logic [orb_pkg::ADDR_W-1:0]   read_pointer;
  logic [orb_pkg::ADDR_W-1:0]   read_pointer_next;
  logic [orb_pkg::CNT_W-1:0]    stored_count;
  logic [orb_pkg::CNT_W-1:0]    stored_count_next;
  logic [orb_pkg::ADDR_W-1:0]   burst_addr;
  logic [orb_pkg::ADDR_W-1:0]   burst_addr_next;
  logic [orb_pkg::REQ_W-1:0]    burst_left;
  logic [orb_pkg::REQ_W-1:0]    burst_left_next;
  logic [orb_pkg::REQ_W-1:0]    burst_total;
  logic [orb_pkg::REQ_W-1:0]    burst_total_next;
  orb_pkg::stage_t              stage_next;

  logic [2:0]                   occupancy;
  logic                         credit_ok;
  logic                         accept;
  logic [orb_pkg::CNT_W-1:0]    clamp_wide;
  logic [orb_pkg::REQ_W-1:0]    clamp_n;

  // A new result may enter the pipe only if the queue can still hold it when it lands.
  assign occupancy = {1'b0, q_count} + {2'b00, stage.valid} - {2'b00, q_pop};
  assign credit_ok = (occupancy <= 3'd1);
  assign in_stall  = !((state == ST_IDLE) && credit_ok);
  assign accept    = in_valid && !in_stall;

  // Request clamped to the fill level and to the burst limit.
  always_comb begin
    clamp_wide = orb_pkg::CNT_W'(request_count);
    if (clamp_wide > stored_count) begin
      clamp_wide = stored_count;
    end
    if (clamp_wide > orb_pkg::CNT_W'(orb_pkg::MAX_BURST)) begin
      clamp_wide = orb_pkg::CNT_W'(orb_pkg::MAX_BURST);
    end
    clamp_n = clamp_wide[orb_pkg::REQ_W-1:0];
  end

  // Writes land only while idle and reads only during a burst, so the two ports
  // never touch the same entry in one cycle and no forwarding is needed.
  assign ram_we    = accept && (func == orb_pkg::FUNC_WRITE);
  assign ram_waddr = write_pointer;
  assign ram_wdata = sample_in;
  assign ram_re    = (state == ST_BURST) && credit_ok;
  assign ram_raddr = burst_addr;

  // Next-state logic for the operations and the burst sequencer.
  always_comb begin
    state_next                       = state;
    write_pointer_next               = write_pointer;
    read_pointer_next                = read_pointer;
    stored_count_next                = stored_count;
    burst_addr_next                  = burst_addr;
    burst_left_next                  = burst_left;
    burst_total_next                 = burst_total;
    stage_next                       = stage;
    stage_next.valid                 = 1'b0;
    stage_next.use_ram               = 1'b0;
    stage_next.res.sample            = '0;
    stage_next.res.sample_valid      = 1'b0;
    stage_next.res.last_of_run       = 1'b1;
    stage_next.res.delivered_count   = '0;
    stage_next.res.status            = orb_pkg::STATUS_OK;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          stage_next.valid          = 1'b1;
          stage_next.res.fill_level = stored_count;
          case (func)
            orb_pkg::FUNC_WRITE: begin
              write_pointer_next = orb_pkg::wrap_inc(write_pointer);
              if (stored_count < orb_pkg::CNT_W'(orb_pkg::DEPTH)) begin
                stored_count_next = stored_count + orb_pkg::CNT_W'(1);
              end else begin
                read_pointer_next = orb_pkg::wrap_inc(read_pointer);
              end
              stage_next.res.fill_level = stored_count_next;
            end
            orb_pkg::FUNC_READ: begin
              if (clamp_n != '0) begin
                stage_next.valid  = 1'b0;
                stored_count_next = stored_count - orb_pkg::CNT_W'(clamp_n);
                read_pointer_next = orb_pkg::wrap_fold(
                  orb_pkg::SUM_W'(read_pointer) + orb_pkg::SUM_W'(clamp_n));
                burst_addr_next   = read_pointer;
                burst_left_next   = clamp_n;
                burst_total_next  = clamp_n;
                state_next        = ST_BURST;
              end
            end
            orb_pkg::FUNC_PEEK: begin
              if (stored_count == '0) begin
                stage_next.res.status = orb_pkg::STATUS_EMPTY;
              end else if (clamp_n != '0) begin
                stage_next.valid = 1'b0;
                burst_addr_next  = orb_pkg::wrap_fold(
                  orb_pkg::SUM_W'(write_pointer) + orb_pkg::SUM_W'(orb_pkg::DEPTH)
                  - orb_pkg::SUM_W'(clamp_n));
                burst_left_next  = clamp_n;
                burst_total_next = clamp_n;
                state_next       = ST_BURST;
              end
            end
            default: begin
              write_pointer_next        = '0;
              read_pointer_next         = '0;
              stored_count_next         = '0;
              stage_next.res.fill_level = '0;
            end
          endcase
        end
      end
      ST_BURST: begin
        // One memory read per cycle while the queue has room.
        if (credit_ok) begin
          stage_next.valid               = 1'b1;
          stage_next.use_ram             = 1'b1;
          stage_next.res.sample_valid    = 1'b1;
          stage_next.res.last_of_run     = (burst_left == orb_pkg::REQ_W'(1));
          stage_next.res.delivered_count = burst_total;
          stage_next.res.fill_level      = stored_count;
          burst_addr_next                = orb_pkg::wrap_inc(burst_addr);
          burst_left_next                = burst_left - orb_pkg::REQ_W'(1);
          if (burst_left == orb_pkg::REQ_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers and the staged result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      stored_count  <= '0;
      stage.valid   <= 1'b0;
    end else begin
      state         <= state_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      stored_count  <= stored_count_next;
      stage         <= stage_next;
    end
  end

  // Burst bookkeeping.
  always_ff @(posedge clk) begin
    burst_addr    <= burst_addr_next;
    burst_left    <= burst_left_next;
    burst_total   <= burst_total_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/overwrite_ring_buffer_with_peek.sv =====
// Top level of the overwriting sample ring buffer with peek of the newest samples.
// Depends on orb_pkg, orb_ram, orb_outq and orb_ctrl.
//
//   Channel   Handshake           Payload
//   input     in_valid/in_stall   func, sample_in, request_count
//   output    out_valid/out_stall sample_out, sample_valid, last_of_run,
//                                 delivered_count, fill_level, status
//
// Write, clear and every request that yields a single result finish without a burst.
// A read or peek of n samples sets up a burst, then makes one RAM read per cycle while
// the result queue has room; the single read port of the sample RAM sets that pace.
// Reset clears pointers and fill count at once; the sample RAM is not cleared.
// A stalled output holds the two-entry result queue and the burst pauses with it.
`default_nettype none

module overwrite_ring_buffer_with_peek (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        func,
  input  wire logic signed [orb_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic [orb_pkg::REQ_W-1:0]         request_count,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [orb_pkg::SAMPLE_W-1:0]    sample_out,
  output logic                                   sample_valid,
  output logic                                   last_of_run,
  output logic [orb_pkg::REQ_W-1:0]              delivered_count,
  output logic [orb_pkg::CNT_W-1:0]              fill_level,
  output logic                                   status
);

  logic                           ram_we;
  logic [orb_pkg::ADDR_W-1:0]     ram_waddr;
  logic [orb_pkg::SAMPLE_W-1:0]   ram_wdata;
  logic                           ram_re;
  logic [orb_pkg::ADDR_W-1:0]     ram_raddr;
  logic [orb_pkg::SAMPLE_W-1:0]   ram_rdata;
  orb_pkg::stage_t                stage;
  orb_pkg::result_t               push_data;
  orb_pkg::result_t               head_data;
  logic [orb_pkg::QCNT_W-1:0]     q_count;
  logic                           q_pop;

  orb_ram #(
    .DEPTH  (orb_pkg::DEPTH),
    .ADDR_W (orb_pkg::ADDR_W),
    .DATA_W (orb_pkg::SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  orb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .sample_in     (sample_in),
    .request_count (request_count),
    .q_count       (q_count),
    .q_pop         (q_pop),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .stage         (stage)
  );

  // Merge the RAM data into the staged result as it lands.
  always_comb begin
    push_data = stage.res;
    if (stage.use_ram) begin
      push_data.sample = ram_rdata;
    end
  end

  orb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (stage.valid),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (head_data),
    .count     (q_count)
  );

  // Output channel driven from the queue head.
  assign out_valid       = (q_count != '0);
  assign q_pop           = out_valid && !out_stall;
  assign sample_out      = head_data.sample;
  assign sample_valid    = head_data.sample_valid;
  assign last_of_run     = head_data.last_of_run;
  assign delivered_count = head_data.delivered_count;
  assign fill_level      = head_data.fill_level;
  assign status          = head_data.status;

  // The queue never holds more than two results.
  assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("result queue overflow");

  // A delivered sample always belongs to a non-empty burst.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_valid) |-> (delivered_count != '0))
    else $error("sample delivered with zero count");

  // The empty status only ever reports an empty buffer and no sample.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> ((fill_level == '0) && !sample_valid && last_of_run))
    else $error("empty status on a non-empty result");

  // The fill level never exceeds the buffer depth.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_level <= orb_pkg::CNT_W'(orb_pkg::DEPTH)))
    else $error("fill level above depth");

endmodule

`default_nettype wire

// ===== dv/overwrite_ring_buffer_with_peek_tb.sv =====
// Self-checking testbench for the overwriting sample ring buffer with peek.
// Depends on orb_pkg and overwrite_ring_buffer_with_peek; drives random and directed requests
// against a behavioral copy of the buffer and checks every result in order.
`default_nettype none

module overwrite_ring_buffer_with_peek_tb;

  localparam int unsigned DEPTH           = orb_pkg::DEPTH;
  localparam int unsigned MAX_BURST       = orb_pkg::MAX_BURST;
  localparam int          RANDOM_REQUESTS = 200;
  localparam int          FILL_REQUESTS   = 70;
  localparam int          TAIL_REQUESTS   = 48;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          MAX_REPORTS     = 10;

  // One request as presented on the input channel.
  typedef struct {
    logic [1:0]                         op;
    logic signed [orb_pkg::SAMPLE_W-1:0] sample;
    logic [orb_pkg::REQ_W-1:0]          count;
  } ring_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                in_valid      = 1'b0;
  logic                                in_stall;
  logic [1:0]                          func          = orb_pkg::FUNC_WRITE;
  logic signed [orb_pkg::SAMPLE_W-1:0] sample_in     = '0;
  logic [orb_pkg::REQ_W-1:0]           request_count = '0;
  logic                                out_valid;
  logic                                out_stall     = 1'b0;
  logic signed [orb_pkg::SAMPLE_W-1:0] sample_out;
  logic                                sample_valid;
  logic                                last_of_run;
  logic [orb_pkg::REQ_W-1:0]           delivered_count;
  logic [orb_pkg::CNT_W-1:0]           fill_level;
  logic                                status;

  ring_request_t      queued_requests[$];
  orb_pkg::result_t   awaited_results[$];

  // Behavioral copy of the buffer contents and pointers.
  logic signed [orb_pkg::SAMPLE_W-1:0] ring_store [DEPTH];
  int unsigned ring_wr   = 0;
  int unsigned ring_rd   = 0;
  int unsigned ring_fill = 0;

  int  cycle_count  = 0;
  int  error_count  = 0;
  int  result_index = 0;
  logic tail_phase  = 1'b0;

  always #5 clk = ~clk;

  overwrite_ring_buffer_with_peek DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .func            (func),
    .sample_in       (sample_in),
    .request_count   (request_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample_out      (sample_out),
    .sample_valid    (sample_valid),
    .last_of_run     (last_of_run),
    .delivered_count (delivered_count),
    .fill_level      (fill_level),
    .status          (status)
  );

  // Work out the results of one accepted request and update the buffer copy.
  task automatic predict_ring_results(input ring_request_t req);
    int unsigned n;
    int unsigned slot;
    orb_pkg::result_t r;
    r = '0;
    r.last_of_run = 1'b1;
    n = req.count;
    if (n > ring_fill) n = ring_fill;
    if (n > MAX_BURST) n = MAX_BURST;
    case (req.op)
      orb_pkg::FUNC_WRITE: begin
        ring_store[ring_wr] = req.sample;
        ring_wr = (ring_wr + 1) % DEPTH;
        // A full buffer drops its oldest sample.
        if (ring_fill < DEPTH) begin
          ring_fill++;
        end else begin
          ring_rd = (ring_rd + 1) % DEPTH;
        end
        r.fill_level = orb_pkg::CNT_W'(ring_fill);
        awaited_results.push_back(r);
      end
      orb_pkg::FUNC_READ: begin
        if (n == 0) begin
          r.fill_level = orb_pkg::CNT_W'(ring_fill);
          awaited_results.push_back(r);
        end else begin
          ring_fill -= n;
          for (int unsigned i = 0; i < n; i++) begin
            r.sample          = ring_store[ring_rd];
            r.sample_valid    = 1'b1;
            r.last_of_run     = (i + 1 == n);
            r.delivered_count = orb_pkg::REQ_W'(n);
            r.fill_level      = orb_pkg::CNT_W'(ring_fill);
            r.status          = orb_pkg::STATUS_OK;
            awaited_results.push_back(r);
            ring_rd = (ring_rd + 1) % DEPTH;
          end
        end
      end
      orb_pkg::FUNC_PEEK: begin
        r.fill_level = orb_pkg::CNT_W'(ring_fill);
        if (ring_fill == 0) begin
          r.status = orb_pkg::STATUS_EMPTY;
          awaited_results.push_back(r);
        end else if (n == 0) begin
          awaited_results.push_back(r);
        end else begin
          // The newest n samples, given oldest first.
          slot = (ring_wr + DEPTH - n) % DEPTH;
          for (int unsigned i = 0; i < n; i++) begin
            r.sample          = ring_store[slot];
            r.sample_valid    = 1'b1;
            r.last_of_run     = (i + 1 == n);
            r.delivered_count = orb_pkg::REQ_W'(n);
            r.status          = orb_pkg::STATUS_OK;
            awaited_results.push_back(r);
            slot = (slot + 1) % DEPTH;
          end
        end
      end
      orb_pkg::FUNC_CLEAR: begin
        ring_wr   = 0;
        ring_rd   = 0;
        ring_fill = 0;
        r.fill_level = '0;
        awaited_results.push_back(r);
      end
    endcase
  endtask

  task automatic add_request(input logic [1:0] op, input logic [15:0] sample,
                             input int count);
    ring_request_t req;
    req.op     = op;
    req.sample = sample;
    req.count  = orb_pkg::REQ_W'(count);
    queued_requests.push_back(req);
  endtask

  // Request driver: holds a stalled request, otherwise presents the next one or idles.
  always @(posedge clk) begin
    int gap_left;
    bit gaps_on;
    ring_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_ring_results('{func, sample_in, request_count});
      end
      gaps_on = !tail_phase && (((cycle_count / 64) % 4) != 3);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          req = queued_requests.pop_front();
          in_valid      <= 1'b1;
          func          <= req.op;
          sample_in     <= req.sample;
          request_count <= req.count;
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail_phase <= (queued_requests.size() < TAIL_REQUESTS);
    end
  end

  // Result monitor: random stall bursts and an in-order comparison of every result.
  always @(posedge clk) begin
    int stall_left;
    bit gaps_on;
    bit bad;
    orb_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result %0d: sample=%0d valid=%0b last=%0b count=%0d",
                     result_index, sample_out, sample_valid, last_of_run, delivered_count);
          end
        end else begin
          want = awaited_results.pop_front();
          bad = (sample_out !== want.sample) || (sample_valid !== want.sample_valid) ||
                (last_of_run !== want.last_of_run) ||
                (delivered_count !== want.delivered_count) ||
                (fill_level !== want.fill_level) || (status !== want.status);
          if (bad) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result %0d mismatch: expected sample=%0d valid=%0b last=%0b",
                       result_index, want.sample, want.sample_valid, want.last_of_run);
              $display("  count=%0d fill=%0d status=%0b", want.delivered_count,
                       want.fill_level, want.status);
              $display("  got sample=%0d valid=%0b last=%0b count=%0d fill=%0d status=%0b",
                       sample_out, sample_valid, last_of_run, delivered_count,
                       fill_level, status);
            end
          end
        end
        result_index++;
      end
      gaps_on = !tail_phase && (((cycle_count / 96) % 4) != 2);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    int count;
    logic [1:0] op;

    // Directed requests: empty buffer, sample extremes, clamping and clear.
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 5);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 0);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 3);
    add_request(orb_pkg::FUNC_WRITE, 16'h7FFF, 0);
    add_request(orb_pkg::FUNC_WRITE, 16'h8000, 127);
    add_request(orb_pkg::FUNC_WRITE, 16'h0000, 0);
    add_request(orb_pkg::FUNC_WRITE, 16'hFFFF, 0);
    add_request(orb_pkg::FUNC_WRITE, 16'h0001, 0);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 0);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 3);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 127);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 0);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 2);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 127);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 1);
    add_request(orb_pkg::FUNC_WRITE, 16'h5555, 0);
    add_request(orb_pkg::FUNC_WRITE, 16'hAAAA, 0);
    add_request(orb_pkg::FUNC_CLEAR, 16'hFFFF, 127);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 4);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 4);
    add_request(orb_pkg::FUNC_WRITE, 16'h1234, 0);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 1);
    add_request(orb_pkg::FUNC_CLEAR, 16'h0000, 0);

    // Fill beyond the burst limit so full-length bursts are clamped at the limit.
    for (int k = 0; k < FILL_REQUESTS; k++) begin
      add_request(orb_pkg::FUNC_WRITE, 16'($urandom()), $urandom_range(0, 127));
    end
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 127);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 64);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 65);
    add_request(orb_pkg::FUNC_READ, 16'h0000, 127);
    add_request(orb_pkg::FUNC_WRITE, 16'($urandom()), 0);
    add_request(orb_pkg::FUNC_PEEK, 16'h0000, 64);

    // Random mix, mostly short bursts with an occasional full-range count.
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = orb_pkg::FUNC_WRITE;
      end else if (pick < 70) begin
        op = orb_pkg::FUNC_READ;
      end else if (pick < 95) begin
        op = orb_pkg::FUNC_PEEK;
      end else begin
        op = orb_pkg::FUNC_CLEAR;
      end
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
      add_request(op, 16'($urandom()), count);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every result to arrive.
    while (queued_requests.size() != 0 || in_valid || rst) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) error_count++;

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/orb_pkg.sv
hw/rtl/orb_ram.sv
hw/rtl/orb_outq.sv
hw/rtl/orb_ctrl.sv
hw/rtl/overwrite_ring_buffer_with_peek.sv
dv/overwrite_ring_buffer_with_peek_tb.sv
